>>> rtl/sbbph_pkg.sv
// Shared types, constants and tables of the spectrum band bar block.
package sbbph_pkg;

    localparam int BAND_COUNT     = 16;
    localparam int BIN_COUNT      = 256;
    localparam int MAX_HEIGHT_DEF = 16;

    localparam int BAND_W   = $clog2(BAND_COUNT);
    localparam int BIN_W    = $clog2(BIN_COUNT);
    localparam int MODE_W   = 2;
    localparam int MAG_W    = 24;
    localparam int CFG_W    = 24;
    localparam int CFG_IDX_W = 1;
    localparam int SUM_W    = 32;
    localparam int HEIGHT_W = 5;
    localparam int COLOR_W  = 8;
    localparam int STEP_W   = $clog2(HEIGHT_W);

    // first bin that belongs to band 0
    localparam logic [BIN_W-1:0] BIN_FIRST = BIN_W'(3);

    localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BIN    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RENDER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR   = 1'd1;

    // top bin of each band
    localparam logic [BIN_W-1:0] BAND_UPPER [BAND_COUNT] = '{
        8'd5,   8'd8,   8'd12,  8'd16,  8'd22,  8'd30,  8'd40,  8'd52,
        8'd65,  8'd80,  8'd98,  8'd118, 8'd140, 8'd165, 8'd195, 8'd255
    };

    // band color, {red, green, blue}
    localparam logic [3*COLOR_W-1:0] BAND_RGB [BAND_COUNT] = '{
        24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
        24'h00FFFF, 24'hFF00FF, 24'hFF8000, 24'h8000FF,
        24'h008080, 24'h808000, 24'hFF69B4, 24'h6620C0,
        24'hA07820, 24'h0005FF, 24'h8D0064, 24'h008080
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LOAD,
        ST_DIV,
        ST_FINISH,
        ST_DECAY
    } t_state;

    typedef struct packed {
        logic idle;
        logic clr_sums;
        logic add_bin;
        logic div_init;
        logic div_step;
        logic finish;
        logic decay;
    } t_cmd;

    typedef struct packed {
        logic              in_fire;
        logic [MODE_W-1:0] mode;
        logic              out_free;
        logic              step_last;
        logic              band_last;
    } t_status;

    // {hit, band} for a bin number; hit is low for bins below band 0
    function automatic logic [BAND_W:0] bin_to_band(input logic [BIN_W-1:0] bin);
        logic [BAND_W:0] cnt;
        cnt = '0;
        for (int b = 0; b < BAND_COUNT; b++) begin
            if (bin > BAND_UPPER[b]) begin
                cnt = cnt + 1'b1;
            end
        end
        return {(bin >= BIN_FIRST), cnt[BAND_W-1:0]};
    endfunction

endpackage

>>> rtl/sbbph_in_if.sv
// Input channel: mode, bin number and magnitude with valid/ready.
interface sbbph_in_if;
    logic                            valid;
    logic                            ready;
    logic [sbbph_pkg::MODE_W-1:0]    mode;
    logic [sbbph_pkg::BIN_W-1:0]     bin_index;
    logic [sbbph_pkg::MAG_W-1:0]     magnitude;

    modport source (output valid, output mode, output bin_index, output magnitude,
                    input ready);
    modport sink   (input valid, input mode, input bin_index, input magnitude,
                    output ready);
endinterface

>>> rtl/sbbph_out_if.sv
// Result channel: one band bar with peak and color per beat.
interface sbbph_out_if;
    logic                             valid;
    logic                             ready;
    logic [sbbph_pkg::BAND_W-1:0]     band;
    logic [sbbph_pkg::HEIGHT_W-1:0]   bar_rows;
    logic [sbbph_pkg::HEIGHT_W-1:0]   peak_level;
    logic [sbbph_pkg::COLOR_W-1:0]    red;
    logic [sbbph_pkg::COLOR_W-1:0]    green;
    logic [sbbph_pkg::COLOR_W-1:0]    blue;
    logic                             last;

    modport source (output valid, output band, output bar_rows, output peak_level,
                    output red, output green, output blue, output last, input ready);
    modport sink   (input valid, input band, input bar_rows, input peak_level,
                    input red, input green, input blue, input last, output ready);
endinterface

>>> rtl/sbbph_ctrl.sv
// Controller state machine: sequences bin, start and render items.
module sbbph_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sbbph_pkg::t_status  i_status,
    output sbbph_pkg::t_cmd     o_cmd
);

    sbbph_pkg::t_state r_state;
    sbbph_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbbph_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            sbbph_pkg::ST_IDLE: begin
                o_cmd.idle = 1'b1;
                if (i_status.in_fire) begin
                    n_state = sbbph_pkg::ST_DISPATCH;
                end
            end
            sbbph_pkg::ST_DISPATCH: begin
                case (i_status.mode)
                    sbbph_pkg::MODE_START: begin
                        o_cmd.clr_sums = 1'b1;
                        n_state        = sbbph_pkg::ST_IDLE;
                    end
                    sbbph_pkg::MODE_BIN: begin
                        o_cmd.add_bin = 1'b1;
                        n_state       = sbbph_pkg::ST_IDLE;
                    end
                    sbbph_pkg::MODE_RENDER: begin
                        n_state = sbbph_pkg::ST_LOAD;
                    end
                    default: begin
                        n_state = sbbph_pkg::ST_IDLE;   // unused mode
                    end
                endcase
            end
            sbbph_pkg::ST_LOAD: begin
                o_cmd.div_init = 1'b1;
                n_state        = sbbph_pkg::ST_DIV;
            end
            sbbph_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.step_last) begin
                    n_state = sbbph_pkg::ST_FINISH;
                end
            end
            sbbph_pkg::ST_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = i_status.band_last ? sbbph_pkg::ST_DECAY
                                                 : sbbph_pkg::ST_LOAD;
                end
            end
            sbbph_pkg::ST_DECAY: begin
                o_cmd.decay = 1'b1;
                n_state     = sbbph_pkg::ST_IDLE;
            end
            default: begin
                n_state = sbbph_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/sbbph_dp.sv
// Datapath: band sums, height divider, smoothing, peak hold, result register.
module sbbph_dp #(
    parameter int MAX_HEIGHT = sbbph_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sbbph_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sbbph_pkg::CFG_W-1:0]       i_cfg_data,
    sbbph_in_if.sink                          i_in,
    sbbph_out_if.source                       o_out,
    input  sbbph_pkg::t_cmd                   i_cmd,
    output sbbph_pkg::t_status                o_status
);

    localparam int BAND_COUNT = sbbph_pkg::BAND_COUNT;
    localparam int BAND_W     = sbbph_pkg::BAND_W;
    localparam int SUM_W      = sbbph_pkg::SUM_W;
    localparam int HEIGHT_W   = sbbph_pkg::HEIGHT_W;
    localparam int STEP_W     = sbbph_pkg::STEP_W;
    localparam int CFG_W      = sbbph_pkg::CFG_W;
    localparam int LIMIT_W    = CFG_W + HEIGHT_W + 1;

    localparam logic [HEIGHT_W-1:0] MAX_H = HEIGHT_W'(MAX_HEIGHT);
    localparam logic [LIMIT_W-1:0]  LIMIT_MUL = LIMIT_W'(MAX_HEIGHT + 1);
    localparam logic [BAND_W-1:0]   BAND_LAST = BAND_W'(BAND_COUNT - 1);
    localparam logic [STEP_W-1:0]   STEP_FIRST = STEP_W'(HEIGHT_W - 1);

    // config
    logic [CFG_W-1:0] r_noise_thr;
    logic [CFG_W-1:0] r_divisor;

    // latched input item
    logic [sbbph_pkg::MODE_W-1:0] r_mode;
    logic [sbbph_pkg::BIN_W-1:0]  r_bin;
    logic [sbbph_pkg::MAG_W-1:0]  r_mag;

    // per-band state
    logic [SUM_W-1:0]    r_band_sum  [BAND_COUNT];
    logic [HEIGHT_W-1:0] r_prev_h    [BAND_COUNT];
    logic [HEIGHT_W-1:0] r_peak      [BAND_COUNT];

    // render walk and divider
    logic [BAND_W-1:0]   r_band;
    logic [STEP_W-1:0]   r_step;
    logic [SUM_W-1:0]    r_rem;
    logic [HEIGHT_W-1:0] r_quo;
    logic                r_clamp;

    // result register
    logic                                 r_out_valid;
    logic [BAND_W-1:0]                    r_out_band;
    logic [HEIGHT_W-1:0]                  r_out_h;
    logic [HEIGHT_W-1:0]                  r_out_peak;
    logic [3*sbbph_pkg::COLOR_W-1:0]      r_out_rgb;
    logic                                 r_out_last;

    logic                in_fire;
    logic [BAND_W:0]     bin_hit_band;
    logic [BAND_W-1:0]   rd_addr;
    logic [SUM_W-1:0]    rd_sum;
    logic [SUM_W:0]      sum_ext;
    logic [SUM_W-1:0]    sat_sum;
    logic [LIMIT_W-1:0]  limit;
    logic [SUM_W-1:0]    div_shift;
    logic                rem_ge;
    logic [HEIGHT_W-1:0] raw_h;
    logic [HEIGHT_W:0]   avg_sum;
    logic [HEIGHT_W-1:0] n_height;
    logic [HEIGHT_W-1:0] n_peak;
    logic                out_free;

    assign in_fire      = i_in.valid & i_cmd.idle;
    assign i_in.ready   = i_cmd.idle;

    assign bin_hit_band = sbbph_pkg::bin_to_band(r_bin);
    assign rd_addr      = (r_mode == sbbph_pkg::MODE_RENDER) ? r_band
                                                             : bin_hit_band[BAND_W-1:0];
    assign rd_sum       = r_band_sum[rd_addr];

    // saturating accumulate
    assign sum_ext = {1'b0, rd_sum} + (SUM_W + 1)'(r_mag);
    assign sat_sum = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

    // quotient beyond MAX_HEIGHT (or zero divisor) -> clamp
    assign limit     = LIMIT_W'(r_divisor) * LIMIT_MUL;
    assign div_shift = SUM_W'(r_divisor) << r_step;
    assign rem_ge    = (r_rem >= div_shift);

    assign raw_h    = r_clamp ? MAX_H : r_quo;
    assign avg_sum  = {1'b0, r_prev_h[r_band]} + {1'b0, raw_h};
    assign n_height = avg_sum[HEIGHT_W:1];
    assign n_peak   = (n_height > r_peak[r_band]) ? n_height : r_peak[r_band];

    assign out_free = ~r_out_valid | o_out.ready;

    assign o_status.in_fire   = in_fire;
    assign o_status.mode      = r_mode;
    assign o_status.out_free  = out_free;
    assign o_status.step_last = (r_step == '0);
    assign o_status.band_last = (r_band == BAND_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise_thr <= '0;
            r_divisor   <= CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sbbph_pkg::CFG_NOISE_THR: r_noise_thr <= i_cfg_data;
                sbbph_pkg::CFG_DIVISOR:   r_divisor   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode <= i_in.mode;
            r_bin  <= i_in.bin_index;
            r_mag  <= i_in.magnitude;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_sums) begin
            for (int b = 0; b < BAND_COUNT; b++) begin
                r_band_sum[b] <= '0;
            end
        end else if (i_cmd.add_bin && bin_hit_band[BAND_W] && (r_mag > r_noise_thr)) begin
            r_band_sum[rd_addr] <= sat_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < BAND_COUNT; b++) begin
                r_prev_h[b] <= '0;
                r_peak[b]   <= '0;
            end
        end else if (i_cmd.finish) begin
            r_prev_h[r_band] <= n_height;
            r_peak[r_band]   <= n_peak;
        end else if (i_cmd.decay) begin
            for (int b = 0; b < BAND_COUNT; b++) begin
                if (r_peak[b] != '0) begin
                    r_peak[b] <= r_peak[b] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || in_fire) begin
            r_band <= '0;
        end else if (i_cmd.finish) begin
            r_band <= r_band + 1'b1;
        end
    end

    // restoring division, one quotient bit per cycle, MSB first
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_clamp <= ({(SUM_W - LIMIT_W)'(0), limit} <= rd_sum);
            r_rem   <= rd_sum;
            r_quo   <= '0;
            r_step  <= STEP_FIRST;
        end else if (i_cmd.div_step) begin
            if (rem_ge) begin
                r_rem <= r_rem - div_shift;
            end
            r_quo  <= {r_quo[HEIGHT_W-2:0], rem_ge};
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_band <= r_band;
            r_out_h    <= n_height;
            r_out_peak <= n_peak;
            r_out_rgb  <= sbbph_pkg::BAND_RGB[r_band];
            r_out_last <= (r_band == BAND_LAST);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.band       = r_out_band;
    assign o_out.bar_rows   = r_out_h;
    assign o_out.peak_level = r_out_peak;
    assign o_out.red        = r_out_rgb[3*sbbph_pkg::COLOR_W-1:2*sbbph_pkg::COLOR_W];
    assign o_out.green      = r_out_rgb[2*sbbph_pkg::COLOR_W-1:sbbph_pkg::COLOR_W];
    assign o_out.blue       = r_out_rgb[sbbph_pkg::COLOR_W-1:0];
    assign o_out.last       = r_out_last;

endmodule

>>> rtl/spectrum_band_bar_peak_hold.sv
// Spectrum band bars with peak hold: top level joining controller and datapath.
//
// Usage:
//   i_in   valid/ready channel; each beat carries mode, bin_index, magnitude.
//          mode start clears the 16 band sums, mode bin adds a magnitude above
//          the noise threshold to its band, mode render emits 16 band beats.
//          The unused mode is dropped with no effect.
//   o_out  valid/ready channel; one beat per band with height, peak, color,
//          and last set on band 15.
//   cfg    i_cfg_we / i_cfg_idx / i_cfg_data; 0 = noise threshold, 1 = divisor.
//          Write only while the block is idle.
// Sequence:
//   Start and bin items are accepted in idle and applied in the dispatch step;
//   ready drops meanwhile. A render walks each band through a load/clamp check,
//   a restoring divider (one quotient bit per cycle) and a finish step; peaks
//   decay once after the last band.
// Stall: a single result register holds a beat; while it is not taken the
//   walk waits in its finish step. The next item is accepted while the last
//   beat still waits.
// Reset: sums, heights and peaks clear, threshold 0, divisor 1, no beat pending.
module spectrum_band_bar_peak_hold #(
    parameter int MAX_HEIGHT = sbbph_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sbbph_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sbbph_pkg::CFG_W-1:0]       i_cfg_data,
    sbbph_in_if.sink                          i_in,
    sbbph_out_if.source                       o_out
);

    sbbph_pkg::t_cmd    cmd;
    sbbph_pkg::t_status status;

    sbbph_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sbbph_dp #(
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cmd      (cmd),
        .o_status   (status)
    );

endmodule
